>>> src/tpmppt_pkg.sv
// ----------------------------------------------------------------------------
// tpmppt_pkg - shared types and constants of the three-point MPPT tracker
// Field widths, register indexes, phase codes and the power magnitude helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmppt_pkg;

    localparam int VOLT_BITS  = 16;
    localparam int POWER_BITS = 32;
    localparam int CFG_BITS   = 16;
    localparam int STEP_BITS  = 16;
    localparam int CNT_BITS   = 16;
    localparam int PHASE_BITS = 2;
    localparam int RUN_BITS   = 4;
    localparam int HOLD_BITS  = 5;
    localparam int IDX_BITS   = 3;

    // Perturbed target: wide enough that voltage +/- step never wraps
    localparam int TGT_BITS = ((VOLT_BITS > STEP_BITS) ? VOLT_BITS : STEP_BITS) + 2;

    // Register indexes on the configuration port
    localparam logic [IDX_BITS-1:0] REG_UPDATE_INTERVAL = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_INITIAL_STEP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_STEP_MAX        = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_STEP_MIN        = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_SETPOINT_MAX    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_SETPOINT_MIN    = 3'd5;

    // Register reset values
    localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0] INIT_STEP_RESET = 16'd16;
    localparam logic [CFG_BITS-1:0] STEP_MAX_RESET = 16'd256;
    localparam logic [CFG_BITS-1:0] STEP_MIN_RESET = 16'd4;
    localparam logic [CFG_BITS-1:0] SP_MAX_RESET   = 16'hFFFF;
    localparam logic [CFG_BITS-1:0] SP_MIN_RESET   = 16'd0;

    // Adaptation thresholds
    localparam logic [RUN_BITS-1:0]  RUN_LIMIT  = 4'd10;
    localparam logic [HOLD_BITS-1:0] HOLD_LIMIT = 5'd20;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_REF  = 2'd0,
        PH_UP   = 2'd1,
        PH_DOWN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] interval;
        logic [CFG_BITS-1:0] step_max;
        logic [CFG_BITS-1:0] step_min;
        logic [CFG_BITS-1:0] sp_max;
        logic [CFG_BITS-1:0] sp_min;
    } cfg_t;

    typedef struct packed {
        logic                  enable;
        logic [VOLT_BITS-1:0]  volt;
        logic [POWER_BITS-1:0] pwr_mag;
    } item_t;

    typedef struct packed {
        logic [VOLT_BITS-1:0] setpoint;
        logic [STEP_BITS-1:0] step;
        phase_t               phase;
    } result_t;

    // Two's complement magnitude; the most negative value maps to 2^(N-1)
    function automatic logic [POWER_BITS-1:0] magnitude(input logic [POWER_BITS-1:0] raw);
        logic [POWER_BITS-1:0] neg;
        neg = ~raw + 1'b1;
        return raw[POWER_BITS-1] ? neg : raw;
    endfunction

endpackage

`default_nettype wire

>>> src/tpmppt_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpmppt_cfg_regs - configuration register file
// Plain write port; indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmppt_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpmppt_pkg::IDX_BITS-1:0] cfg_wr_index,
    input  wire logic [tpmppt_pkg::CFG_BITS-1:0] cfg_wr_data,
    output tpmppt_pkg::cfg_t                   cfg
);

    tpmppt_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval <= tpmppt_pkg::INTERVAL_RESET;
            cfg_reg.step_max <= tpmppt_pkg::STEP_MAX_RESET;
            cfg_reg.step_min <= tpmppt_pkg::STEP_MIN_RESET;
            cfg_reg.sp_max   <= tpmppt_pkg::SP_MAX_RESET;
            cfg_reg.sp_min   <= tpmppt_pkg::SP_MIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                tpmppt_pkg::REG_UPDATE_INTERVAL: cfg_reg.interval <= cfg_wr_data;
                // Initial step only matters at reset, where it is always its
                // reset value, so the write has nothing to change
                tpmppt_pkg::REG_INITIAL_STEP:    ;
                tpmppt_pkg::REG_STEP_MAX:        cfg_reg.step_max <= cfg_wr_data;
                tpmppt_pkg::REG_STEP_MIN:        cfg_reg.step_min <= cfg_wr_data;
                tpmppt_pkg::REG_SETPOINT_MAX:    cfg_reg.sp_max   <= cfg_wr_data;
                tpmppt_pkg::REG_SETPOINT_MIN:    cfg_reg.sp_min   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/tpmppt_in_stage.sv
// ----------------------------------------------------------------------------
// tpmppt_in_stage - input register
// Capture one beat and its power magnitude; hold it until the update advances.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmppt_in_stage (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_enable,
    input  wire logic [tpmppt_pkg::VOLT_BITS-1:0]         s_dc_voltage,
    input  wire logic signed [tpmppt_pkg::POWER_BITS-1:0] s_power_sample,
    input  wire logic                                   advance,
    output logic                                        item_valid,
    output tpmppt_pkg::item_t                           item
);

    logic              valid_reg;
    tpmppt_pkg::item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.enable  <= s_enable;
            item_reg.volt    <= s_dc_voltage;
            item_reg.pwr_mag <= tpmppt_pkg::magnitude(s_power_sample);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> src/tpmppt_update.sv
// ----------------------------------------------------------------------------
// tpmppt_update - tracker state and single-pass update logic
// Tick counting, three-phase perturbation, decision, step adaptation, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmppt_update (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          go,
    input  wire tpmppt_pkg::item_t item,
    input  wire tpmppt_pkg::cfg_t  cfg,
    output logic               fire,
    output tpmppt_pkg::result_t result
);

    localparam int TB = tpmppt_pkg::TGT_BITS;
    localparam int SB = tpmppt_pkg::STEP_BITS;

    logic [tpmppt_pkg::CNT_BITS-1:0]   tick_count_reg, tick_count_next, cnt_inc;
    tpmppt_pkg::phase_t                phase_reg, phase_next, phase_upd;
    logic [tpmppt_pkg::POWER_BITS-1:0] ref_power_reg, ref_power_next;
    logic [tpmppt_pkg::POWER_BITS-1:0] up_power_reg, up_power_next;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  ref_voltage_reg, ref_voltage_next;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  up_voltage_reg, up_voltage_next;
    logic [SB-1:0]                     step_reg, step_next, step_upd, step_half;
    logic [SB:0]                       step_dbl;
    logic [tpmppt_pkg::RUN_BITS-1:0]   rise_run_reg, rise_run_next, rise_upd;
    logic [tpmppt_pkg::RUN_BITS-1:0]   fall_run_reg, fall_run_next, fall_upd;
    logic [tpmppt_pkg::HOLD_BITS-1:0]  hold_run_reg, hold_run_next, hold_upd;
    logic signed [TB-1:0]              target, clamp_hi, clamp_lo, sp_max_s, sp_min_s;

    always_comb begin
        cnt_inc = tick_count_reg + 1'b1;
        fire    = go && item.enable && (cnt_inc >= cfg.interval);

        tick_count_next  = tick_count_reg;
        phase_next       = phase_reg;
        ref_power_next   = ref_power_reg;
        up_power_next    = up_power_reg;
        ref_voltage_next = ref_voltage_reg;
        up_voltage_next  = up_voltage_reg;
        step_next        = step_reg;
        rise_run_next    = rise_run_reg;
        fall_run_next    = fall_run_reg;
        hold_run_next    = hold_run_reg;

        rise_upd = rise_run_reg;
        fall_upd = fall_run_reg;
        hold_upd = hold_run_reg;

        if (go && item.enable) begin
            tick_count_next = fire ? '0 : cnt_inc;
        end

        // Phase action and perturbed or chosen target
        unique case (phase_reg)
            tpmppt_pkg::PH_UP: begin
                target    = $signed(TB'(ref_voltage_reg)) - $signed(TB'(step_reg));
                phase_upd = tpmppt_pkg::PH_DOWN;
            end
            tpmppt_pkg::PH_DOWN: begin
                phase_upd = tpmppt_pkg::PH_REF;
                if (ref_power_reg > up_power_reg && ref_power_reg < item.pwr_mag) begin
                    target   = $signed(TB'(item.volt));
                    rise_upd = rise_run_reg + 1'b1;
                    fall_upd = '0;
                    hold_upd = '0;
                end else if (ref_power_reg < up_power_reg && ref_power_reg > item.pwr_mag) begin
                    target   = $signed(TB'(up_voltage_reg));
                    fall_upd = fall_run_reg + 1'b1;
                    rise_upd = '0;
                    hold_upd = '0;
                end else begin
                    target   = $signed(TB'(ref_voltage_reg));
                    hold_upd = hold_run_reg + 1'b1;
                    rise_upd = '0;
                    fall_upd = '0;
                end
            end
            default: begin
                target    = $signed(TB'(item.volt)) + $signed(TB'(step_reg));
                phase_upd = tpmppt_pkg::PH_UP;
            end
        endcase

        // Step adaptation
        step_dbl  = {step_reg, 1'b0};
        step_half = step_reg >> 1;
        step_upd  = step_reg;
        if (rise_upd >= tpmppt_pkg::RUN_LIMIT || fall_upd >= tpmppt_pkg::RUN_LIMIT) begin
            rise_upd = '0;
            fall_upd = '0;
            step_upd = (step_dbl > {1'b0, cfg.step_max}) ? cfg.step_max : step_dbl[SB-1:0];
        end else if (hold_upd >= tpmppt_pkg::HOLD_LIMIT) begin
            hold_upd = '0;
            step_upd = (step_half < cfg.step_min) ? cfg.step_min : step_half;
        end

        // Clamp to max first, then min, so min wins when the limits cross
        sp_max_s = $signed(TB'(cfg.sp_max));
        sp_min_s = $signed(TB'(cfg.sp_min));
        clamp_hi = (target > sp_max_s) ? sp_max_s : target;
        clamp_lo = (clamp_hi < sp_min_s) ? sp_min_s : clamp_hi;

        if (fire) begin
            phase_next    = phase_upd;
            step_next     = step_upd;
            rise_run_next = rise_upd;
            fall_run_next = fall_upd;
            hold_run_next = hold_upd;
            unique case (phase_reg)
                tpmppt_pkg::PH_UP: begin
                    up_power_next   = item.pwr_mag;
                    up_voltage_next = item.volt;
                end
                tpmppt_pkg::PH_DOWN: ;
                default: begin
                    ref_power_next   = item.pwr_mag;
                    ref_voltage_next = item.volt;
                end
            endcase
        end

        result.setpoint = clamp_lo[tpmppt_pkg::VOLT_BITS-1:0];
        result.step     = step_upd;
        result.phase    = phase_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            phase_reg       <= tpmppt_pkg::PH_REF;
            ref_power_reg   <= '0;
            up_power_reg    <= '0;
            ref_voltage_reg <= '0;
            up_voltage_reg  <= '0;
            step_reg        <= tpmppt_pkg::INIT_STEP_RESET;
            rise_run_reg    <= '0;
            fall_run_reg    <= '0;
            hold_run_reg    <= '0;
        end else begin
            tick_count_reg  <= tick_count_next;
            phase_reg       <= phase_next;
            ref_power_reg   <= ref_power_next;
            up_power_reg    <= up_power_next;
            ref_voltage_reg <= ref_voltage_next;
            up_voltage_reg  <= up_voltage_next;
            step_reg        <= step_next;
            rise_run_reg    <= rise_run_next;
            fall_run_reg    <= fall_run_next;
            hold_run_reg    <= hold_run_next;
        end
    end

    a_fire_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> tick_count_reg == '0)
        else $error("tick count not cleared after an update");

    a_idle_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(phase_reg) && $stable(step_reg))
        else $error("phase or step moved without an update");

    a_ref_to_up: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == tpmppt_pkg::PH_REF |=> phase_reg == tpmppt_pkg::PH_UP)
        else $error("reference phase did not advance to up");

    a_down_to_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg == tpmppt_pkg::PH_DOWN |=> phase_reg == tpmppt_pkg::PH_REF)
        else $error("down phase did not return to reference");

endmodule

`default_nettype wire

>>> src/three_point_mppt_tracker_core.sv
// ----------------------------------------------------------------------------
// three_point_mppt_tracker_core - three-point perturb-and-observe MPPT
// Each input beat is held in the input register; a beat that causes an update
// loads its result into the result register. Throughput: one input beat per cycle
// unless a full result register is blocked, set by the single-pass update logic.
// Reset (aresetn low, synchronous): registers to defaults, tracker state
// cleared, step loaded with the initial step default, both channels emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module three_point_mppt_tracker_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [tpmppt_pkg::IDX_BITS-1:0]          cfg_wr_index,
    input  wire logic [tpmppt_pkg::CFG_BITS-1:0]          cfg_wr_data,
    // input channel: one beat per tick
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_enable,
    input  wire logic [tpmppt_pkg::VOLT_BITS-1:0]         s_dc_voltage,
    input  wire logic signed [tpmppt_pkg::POWER_BITS-1:0] s_power_sample,
    // result channel: one beat per update
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [tpmppt_pkg::VOLT_BITS-1:0]              m_voltage_setpoint,
    output logic [tpmppt_pkg::STEP_BITS-1:0]              m_current_step,
    output logic [tpmppt_pkg::PHASE_BITS-1:0]             m_next_phase
);

    tpmppt_pkg::cfg_t    cfg;
    tpmppt_pkg::item_t   item;
    tpmppt_pkg::result_t result;
    tpmppt_pkg::result_t result_reg;
    logic                item_valid;
    logic                advance;
    logic                fire;
    logic                m_valid_reg;

    tpmppt_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Advance the held beat whenever the result slot is empty or being taken;
    // beats that cause no result still pass through; enabled ones update the tick count.
    assign advance = item_valid && (!m_valid_reg || m_ready);

    tpmppt_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_enable       (s_enable),
        .s_dc_voltage   (s_dc_voltage),
        .s_power_sample (s_power_sample),
        .advance        (advance),
        .item_valid     (item_valid),
        .item           (item)
    );

    tpmppt_update u_upd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (advance),
        .item    (item),
        .cfg     (cfg),
        .fire    (fire),
        .result  (result)
    );

    // Result register: load on an update, drop once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fire;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fire) begin
            result_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_voltage_setpoint = result_reg.setpoint;
    assign m_current_step     = result_reg.step;
    assign m_next_phase       = result_reg.phase;

    // Input side stalls only behind a full, blocked result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

>>> bench/three_point_mppt_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// three_point_mppt_tracker_core_tb - self-checking bench for the MPPT tracker
// Drives tick beats through a valid/ready driver, predicts every setpoint
// update with a cycle-free tracker model and checks each result beat in order,
// across register settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module three_point_mppt_tracker_core_tb;

    localparam int VB            = tpmppt_pkg::VOLT_BITS;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 60;
    localparam int SHAPED_PCT    = 85;

    // Idling per random phase: none, sender only, receiver only, both
    localparam int SEND_IDLE[4]  = '{0, 70, 0, 30};
    localparam int RECV_STALL[4] = '{0, 0, 70, 30};

    typedef struct packed {
        logic                              enable;
        logic [tpmppt_pkg::VOLT_BITS-1:0]  volt;
        logic [tpmppt_pkg::POWER_BITS-1:0] pwr;
    } tick_t;

    typedef enum logic [1:0] {
        TR_RISE,
        TR_FALL,
        TR_HOLD
    } trend_t;

    // ------------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              cfg_wr_en    = 1'b0;
    logic [tpmppt_pkg::IDX_BITS-1:0]   cfg_wr_index = '0;
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_wr_data  = '0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic                              s_enable     = 1'b0;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  s_dc_voltage = '0;
    logic [tpmppt_pkg::POWER_BITS-1:0] s_power_sample = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  m_voltage_setpoint;
    logic [tpmppt_pkg::STEP_BITS-1:0]  m_current_step;
    logic [tpmppt_pkg::PHASE_BITS-1:0] m_next_phase;

    three_point_mppt_tracker_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_enable           (s_enable),
        .s_dc_voltage       (s_dc_voltage),
        .s_power_sample     (s_power_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_voltage_setpoint (m_voltage_setpoint),
        .m_current_step     (m_current_step),
        .m_next_phase       (m_next_phase)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Tracker model: register copies and tracker state, reset values at start
    // ------------------------------------------------------------------------
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_interval = tpmppt_pkg::INTERVAL_RESET;
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_step_max = tpmppt_pkg::STEP_MAX_RESET;
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_step_min = tpmppt_pkg::STEP_MIN_RESET;
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_sp_max   = tpmppt_pkg::SP_MAX_RESET;
    logic [tpmppt_pkg::CFG_BITS-1:0]   cfg_sp_min   = tpmppt_pkg::SP_MIN_RESET;

    logic [tpmppt_pkg::CNT_BITS-1:0]   tick_cnt  = '0;
    tpmppt_pkg::phase_t                trk_phase = tpmppt_pkg::PH_REF;
    logic [tpmppt_pkg::POWER_BITS-1:0] ref_pwr   = '0;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  ref_volt  = '0;
    logic [tpmppt_pkg::POWER_BITS-1:0] up_pwr    = '0;
    logic [tpmppt_pkg::VOLT_BITS-1:0]  up_volt   = '0;
    // The step register takes the initial step only at reset, which is once
    logic [tpmppt_pkg::STEP_BITS-1:0]  step_reg  = tpmppt_pkg::INIT_STEP_RESET;
    logic [tpmppt_pkg::RUN_BITS-1:0]   rise_cnt  = '0;
    logic [tpmppt_pkg::RUN_BITS-1:0]   fall_cnt  = '0;
    logic [tpmppt_pkg::HOLD_BITS-1:0]  hold_cnt  = '0;

    // Stimulus and checking bookkeeping
    tick_t               pending_ticks[$];
    tpmppt_pkg::result_t due_updates[$];
    tick_t               on_bus;
    tpmppt_pkg::result_t next_upd;
    tpmppt_pkg::result_t head_upd;
    int      beats_queued   = 0;
    int      beats_taken    = 0;
    int      mismatches     = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      ready_stall_pct = 0;

    // Generator shadow of the update schedule, resynced whenever idle
    logic [tpmppt_pkg::CNT_BITS-1:0]   gen_tick = '0;
    tpmppt_pkg::phase_t                gen_phase = tpmppt_pkg::PH_REF;
    trend_t                            trend = TR_HOLD;
    int                                trend_left = 0;
    logic [tpmppt_pkg::POWER_BITS-1:0] trend_base = '0;

    // Advance the tracker by one accepted tick; return 1 when it updates
    function automatic bit track_tick(input tick_t t, output tpmppt_pkg::result_t upd);
        logic [tpmppt_pkg::CNT_BITS-1:0]   cnt;
        logic [tpmppt_pkg::POWER_BITS-1:0] mag;
        logic [tpmppt_pkg::STEP_BITS:0]    dbl;
        logic [tpmppt_pkg::STEP_BITS-1:0]  half;
        int                                target;
        upd = '0;
        if (!t.enable)
            return 1'b0;
        cnt = tick_cnt + 1'b1;
        if (cnt < cfg_interval) begin
            tick_cnt = cnt;
            return 1'b0;
        end
        tick_cnt = '0;
        // Magnitude only; the most negative sample wraps to 2^(N-1) exactly
        mag = t.pwr[tpmppt_pkg::POWER_BITS-1] ? -t.pwr : t.pwr;

        case (trk_phase)
            tpmppt_pkg::PH_UP: begin
                up_pwr    = mag;
                up_volt   = t.volt;
                target    = int'(ref_volt) - int'(step_reg);
                trk_phase = tpmppt_pkg::PH_DOWN;
            end
            tpmppt_pkg::PH_DOWN: begin
                trk_phase = tpmppt_pkg::PH_REF;
                if (ref_pwr > up_pwr && ref_pwr < mag) begin
                    target   = int'(t.volt);
                    rise_cnt = rise_cnt + 1'b1;
                    fall_cnt = '0;
                    hold_cnt = '0;
                end else if (ref_pwr < up_pwr && ref_pwr > mag) begin
                    target   = int'(up_volt);
                    fall_cnt = fall_cnt + 1'b1;
                    rise_cnt = '0;
                    hold_cnt = '0;
                end else begin
                    target   = int'(ref_volt);
                    hold_cnt = hold_cnt + 1'b1;
                    rise_cnt = '0;
                    fall_cnt = '0;
                end
            end
            default: begin
                ref_pwr   = mag;
                ref_volt  = t.volt;
                target    = int'(ref_volt) + int'(step_reg);
                trk_phase = tpmppt_pkg::PH_UP;
            end
        endcase

        // Adapt: double after a long run one way, halve after a long hold
        if (rise_cnt >= tpmppt_pkg::RUN_LIMIT || fall_cnt >= tpmppt_pkg::RUN_LIMIT) begin
            rise_cnt = '0;
            fall_cnt = '0;
            dbl      = {step_reg, 1'b0};
            step_reg = (dbl > cfg_step_max) ? cfg_step_max
                                            : dbl[tpmppt_pkg::STEP_BITS-1:0];
        end else if (hold_cnt >= tpmppt_pkg::HOLD_LIMIT) begin
            hold_cnt = '0;
            half     = step_reg >> 1;
            step_reg = (half < cfg_step_min) ? cfg_step_min : half;
        end

        // Upper limit first, then lower, so the lower wins when they cross
        if (target > int'(cfg_sp_max))
            target = int'(cfg_sp_max);
        if (target < int'(cfg_sp_min))
            target = int'(cfg_sp_min);

        upd.setpoint = target[tpmppt_pkg::VOLT_BITS-1:0];
        upd.step     = step_reg;
        upd.phase    = trk_phase;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold each beat until taken, then feed the model and load the next
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (track_tick(on_bus, next_upd))
                    due_updates.push_back(next_upd);
                beats_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_ticks.pop_front();
                    s_valid        <= 1'b1;
                    s_enable       <= on_bus.enable;
                    s_dc_voltage   <= on_bus.volt;
                    s_power_sample <= on_bus.pwr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each update beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_updates.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected update beat: setpoint %0d step %0d phase %0d",
                                 m_voltage_setpoint, m_current_step, m_next_phase);
                    mismatches++;
                end else begin
                    head_upd = due_updates.pop_front();
                    if (m_voltage_setpoint !== head_upd.setpoint ||
                        m_current_step !== head_upd.step ||
                        m_next_phase !== head_upd.phase) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"update beat differs: expected setpoint %0d step %0d ",
                                      "phase %0d, got setpoint %0d step %0d phase %0d"},
                                     head_upd.setpoint, head_upd.step, head_upd.phase,
                                     m_voltage_setpoint, m_current_step, m_next_phase);
                        mismatches++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("three_point_mppt_tracker_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [tpmppt_pkg::IDX_BITS-1:0] idx,
                             input logic [tpmppt_pkg::CFG_BITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tpmppt_pkg::REG_UPDATE_INTERVAL: cfg_interval = val;
            tpmppt_pkg::REG_STEP_MAX:        cfg_step_max = val;
            tpmppt_pkg::REG_STEP_MIN:        cfg_step_min = val;
            tpmppt_pkg::REG_SETPOINT_MAX:    cfg_sp_max   = val;
            tpmppt_pkg::REG_SETPOINT_MIN:    cfg_sp_min   = val;
            default: ;
        endcase
    endtask

    task automatic queue_tick(input logic en, input logic [tpmppt_pkg::VOLT_BITS-1:0] v,
                              input logic [tpmppt_pkg::POWER_BITS-1:0] p);
        tick_t t;
        t.enable = en;
        t.volt   = v;
        t.pwr    = p;
        pending_ticks.push_back(t);
        beats_queued++;
    endtask

    // Wait until every beat is taken and every update has come back, then
    // let the pipeline drain trailing no-update ticks
    task automatic settle();
        while (beats_taken != beats_queued || due_updates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        gen_tick  = tick_cnt;
        gen_phase = trk_phase;
    endtask

    // Queue random ticks; where a tick lands on an update, shape its power so
    // that whole reference/up/down triples form rising, falling or flat runs
    task automatic queue_ticks(input int count, input int shaped_pct);
        logic                              en;
        logic [tpmppt_pkg::VOLT_BITS-1:0]  v;
        logic [tpmppt_pkg::POWER_BITS-1:0] p;
        logic [tpmppt_pkg::POWER_BITS-1:0] mag;
        logic [tpmppt_pkg::CNT_BITS-1:0]   nxt;
        logic [tpmppt_pkg::POWER_BITS-1:0] delta;
        bit                                updates;
        int                                pick;
        for (int i = 0; i < count; i++) begin
            en = ($urandom_range(99) < 90);
            pick = $urandom_range(9);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : VB'($urandom);
            p = $urandom;
            updates = 1'b0;
            if (en) begin
                nxt = gen_tick + 1'b1;
                if (nxt >= cfg_interval) begin
                    updates  = 1'b1;
                    gen_tick = '0;
                end else begin
                    gen_tick = nxt;
                end
            end
            if (updates && $urandom_range(99) < shaped_pct) begin
                delta = $urandom_range(1, 1 << 16);
                case (gen_phase)
                    tpmppt_pkg::PH_UP: begin
                        case (trend)
                            TR_RISE: mag = trend_base - delta;
                            TR_FALL: mag = trend_base + delta;
                            default: mag = $urandom_range(1) ? trend_base : $urandom >> 1;
                        endcase
                    end
                    tpmppt_pkg::PH_DOWN: begin
                        case (trend)
                            TR_RISE: mag = trend_base + delta;
                            TR_FALL: mag = trend_base - delta;
                            default: mag = $urandom_range(1) ? trend_base : $urandom >> 1;
                        endcase
                    end
                    default: begin
                        // Start a new triple; keep the trend for a streak
                        if (trend_left == 0) begin
                            pick = $urandom_range(2);
                            trend = (pick == 0) ? TR_RISE : (pick == 1) ? TR_FALL : TR_HOLD;
                            trend_left = (trend == TR_HOLD) ? $urandom_range(1, 26)
                                                            : $urandom_range(1, 14);
                        end
                        trend_left--;
                        trend_base = $urandom_range(1 << 20, 1 << 30);
                        mag = trend_base;
                    end
                endcase
                p = $urandom_range(1) ? -mag : mag;
            end
            if (updates)
                gen_phase = (gen_phase == tpmppt_pkg::PH_REF) ? tpmppt_pkg::PH_UP :
                            (gen_phase == tpmppt_pkg::PH_UP)  ? tpmppt_pkg::PH_DOWN :
                                                                tpmppt_pkg::PH_REF;
            queue_tick(en, v, p);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int                              pick;
        logic [tpmppt_pkg::CFG_BITS-1:0] v_int;
        logic [tpmppt_pkg::CFG_BITS-1:0] v_smax;
        logic [tpmppt_pkg::CFG_BITS-1:0] v_smin;
        logic [tpmppt_pkg::CFG_BITS-1:0] v_spmax;
        logic [tpmppt_pkg::CFG_BITS-1:0] v_spmin;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: five enabled ticks build a count well below 100
        queue_tick(1'b1, '0, '0);
        queue_tick(1'b1, '1, 32'h7FFF_FFFF);
        queue_tick(1'b0, '1, 32'h8000_0000);
        queue_tick(1'b1, 16'd12345, 32'hFFFF_FFFF);
        queue_tick(1'b1, 16'd1, 32'd1);
        queue_tick(1'b1, 16'd40000, 32'h8000_0000);
        settle();

        // Drop the interval below the count: the next enabled tick updates
        write_reg(tpmppt_pkg::REG_UPDATE_INTERVAL, 16'd1);
        // Most negative reference, up point below the lower limit, then a hold
        queue_tick(1'b1, '0, 32'h8000_0000);
        queue_tick(1'b1, '1, 32'h7FFF_FFFF);
        queue_tick(1'b1, 16'd1234, '0);
        queue_tick(1'b0, '1, 32'h8000_0000);
        // Reference at the top saturates; the most negative down sample wins
        queue_tick(1'b1, '1, 32'h7FFF_FFFF);
        queue_tick(1'b1, 16'd100, 32'd5);
        queue_tick(1'b1, 16'd2000, 32'h8000_0000);
        // Falling triple with negative reference power
        queue_tick(1'b1, 16'd30000, -32'sd1000);
        queue_tick(1'b1, 16'd30016, 32'd2000);
        queue_tick(1'b1, 16'd29984, 32'd500);
        settle();

        // Zero interval with crossed setpoint limits: the lower one wins
        write_reg(tpmppt_pkg::REG_UPDATE_INTERVAL, 16'd0);
        write_reg(tpmppt_pkg::REG_SETPOINT_MAX, 16'd100);
        write_reg(tpmppt_pkg::REG_SETPOINT_MIN, 16'd200);
        queue_tick(1'b1, 16'd50, 32'd7);
        queue_tick(1'b0, 16'd9, 32'd3);
        queue_tick(1'b1, '1, 32'h8000_0001);
        queue_tick(1'b1, 16'd150, 32'd99);
        settle();

        // Crossed step limits; initial step only matters at reset
        write_reg(tpmppt_pkg::REG_INITIAL_STEP, '1);
        write_reg(tpmppt_pkg::REG_STEP_MAX, 16'd20);
        write_reg(tpmppt_pkg::REG_STEP_MIN, 16'd30);
        write_reg(tpmppt_pkg::REG_SETPOINT_MAX, '1);
        write_reg(tpmppt_pkg::REG_SETPOINT_MIN, '0);
        queue_ticks(6, SHAPED_PCT);
        settle();

        // Random phases, each with fresh settings and its own idling pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            send_idle_pct   = SEND_IDLE[ph % 4];
            ready_stall_pct = RECV_STALL[ph % 4];

            pick  = $urandom_range(9);
            v_int = (pick < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);

            pick   = $urandom_range(3);
            v_smax = (pick == 0) ? 16'hFFFF :
                     (pick == 1) ? $urandom_range(1, 8) :
                     (pick == 2) ? $urandom_range(16, 400) : $urandom_range(1, 65535);
            pick   = $urandom_range(5);
            v_smin = (pick == 0) ? 16'd1 :
                     (pick <= 3) ? $urandom_range(1, 8) :
                     (pick == 4) ? $urandom_range(1, 65535) : 16'hFFFF;

            pick = $urandom_range(4);
            if (pick <= 1) begin
                v_spmax = '1;
                v_spmin = '0;
            end else if (pick == 2) begin
                v_spmax = $urandom_range(20000, 65535);
                v_spmin = $urandom_range(0, 20000);
            end else if (pick == 3) begin
                v_spmax = $urandom;
                v_spmin = $urandom;
            end else begin
                v_spmax = $urandom_range(0, 1000);
                v_spmin = '0;
            end

            // The first phase runs with the widest step and setpoint range
            if (ph == 0) begin
                v_smax  = '1;
                v_smin  = 16'd1;
                v_spmax = '1;
                v_spmin = '0;
            end

            write_reg(tpmppt_pkg::REG_UPDATE_INTERVAL, v_int);
            write_reg(tpmppt_pkg::REG_INITIAL_STEP, $urandom_range(1, 65535));
            write_reg(tpmppt_pkg::REG_STEP_MAX, v_smax);
            write_reg(tpmppt_pkg::REG_STEP_MIN, v_smin);
            write_reg(tpmppt_pkg::REG_SETPOINT_MAX, v_spmax);
            write_reg(tpmppt_pkg::REG_SETPOINT_MIN, v_spmin);
            queue_ticks(PHASE_TICKS, SHAPED_PCT);
            settle();
        end

        // Longest interval: a short burst of enabled ticks stays below the count
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        write_reg(tpmppt_pkg::REG_UPDATE_INTERVAL, '1);
        write_reg(tpmppt_pkg::REG_INITIAL_STEP, 16'd1);
        for (int i = 0; i < 8; i++)
            queue_tick(1'b1, VB'($urandom), $urandom);
        settle();

        if (mismatches == 0)
            $display("three_point_mppt_tracker_core: match");
        else
            $display("three_point_mppt_tracker_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/tpmppt_pkg.sv
src/tpmppt_cfg_regs.sv
src/tpmppt_in_stage.sv
src/tpmppt_update.sv
src/three_point_mppt_tracker_core.sv
bench/three_point_mppt_tracker_core_tb.sv
